FILE: hdl/lpc_pkg.sv
`timescale 1ns / 1ps

package lpc_pkg;

    localparam int MAX_DIM     = 64;
    localparam int COUNT_BITS  = 32;
    localparam int DIM_IN_W    = 7;
    localparam int COUNT_OUT_W = 32;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_IN_W > DIM_W) ? DIM_IN_W : DIM_W;
    localparam int STEP_W = $clog2(2 * MAX_DIM);

    typedef logic [COUNT_BITS-1:0] lpc_count_t;
    typedef logic [DIM_IN_W-1:0]   lpc_dim_in_t;
    typedef logic [DIM_W-1:0]      lpc_dim_t;
    typedef logic [STEP_W-1:0]     lpc_step_t;

    // Sequencer commands shared by every cell.
    typedef struct packed {
        logic init;
        logic run;
    } lpc_cell_ctrl_t;

    // Sequencer status for the output stage.
    typedef struct packed {
        logic fin;
        logic zero;
    } lpc_seq_stat_t;

    // Saturate an oversized dimension to MAX_DIM.
    function automatic lpc_dim_t lpc_clamp_dim(input lpc_dim_in_t d);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(d);
        if (wide > CMP_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(wide);
    endfunction

endpackage

FILE: hdl/lpc_cell.sv
`timescale 1ns / 1ps

module lpc_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpc_pkg::lpc_cell_ctrl_t ctrl,
    input  logic                   col_en,
    input  logic                   left_act,
    input  lpc_pkg::lpc_count_t    left_val,
    output logic                   act,
    output lpc_pkg::lpc_count_t    val,
    output logic                   ovf
);
    import lpc_pkg::*;

    lpc_count_t            val_reg;
    lpc_count_t            val_next;
    logic                  act_reg;
    logic                  act_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [COUNT_BITS:0]   sum;

    assign sum = {1'b0, val_reg} + {1'b0, left_val};

    always_comb
    begin
        val_next = val_reg;
        act_next = act_reg;
        ovf_next = ovf_reg;
        if (ctrl.init)
        begin
            val_next = COUNT_BITS'(1);
            act_next = 1'b0;
            ovf_next = 1'b0;
        end
        else if (ctrl.run)
        begin
            act_next = left_act;
            if (!col_en)
            begin
                // past the last column: forward the left value toward the tail
                val_next = left_val;
            end
            else if (left_act)
            begin
                if (sum[COUNT_BITS])
                begin
                    val_next = '1;
                    ovf_next = 1'b1;
                end
                else
                begin
                    val_next = sum[COUNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign act = act_reg;
    assign val = val_reg;
    assign ovf = ovf_reg;

endmodule

FILE: hdl/lpc_seq.sv
`timescale 1ns / 1ps

module lpc_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  lpc_pkg::lpc_dim_in_t    rows,
    input  lpc_pkg::lpc_dim_in_t    cols,
    output logic                    busy,
    output lpc_pkg::lpc_cell_ctrl_t cell_ctrl,
    output logic                    act_src,
    output lpc_pkg::lpc_dim_t       cols_used,
    output lpc_pkg::lpc_seq_stat_t  stat
);
    import lpc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } lpc_state_t;

    lpc_state_t state_reg;
    lpc_state_t state_next;
    lpc_step_t  step_reg;
    lpc_step_t  step_next;
    lpc_step_t  end_reg;
    lpc_step_t  end_next;
    lpc_dim_t   rows_m1_reg;
    lpc_dim_t   rows_m1_next;
    lpc_dim_t   cols_reg;
    lpc_dim_t   cols_next;
    logic       zero_reg;
    logic       zero_next;
    logic       accept;
    logic       zero_in;
    lpc_dim_t   rows_cl;
    lpc_dim_t   cols_cl;
    lpc_dim_t   rows_cl_m1;

    assign accept     = start && (state_reg == ST_IDLE);
    assign zero_in    = (rows == '0) || (cols == '0);
    assign rows_cl    = lpc_clamp_dim(rows);
    assign cols_cl    = lpc_clamp_dim(cols);
    assign rows_cl_m1 = rows_cl - DIM_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        end_next     = end_reg;
        rows_m1_next = rows_m1_reg;
        cols_next    = cols_reg;
        zero_next    = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next    = '0;
                    rows_m1_next = rows_cl_m1;
                    cols_next    = cols_cl;
                    zero_next    = zero_in;
                    // last step: the tail cell holds the final count
                    end_next     = STEP_W'(rows_cl_m1) + STEP_W'(MAX_DIM - 2);
                    state_next   = zero_in ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == end_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg     <= end_next;
        rows_m1_reg <= rows_m1_next;
        cols_reg    <= cols_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cell_ctrl.init = accept && !zero_in;
    assign cell_ctrl.run  = (state_reg == ST_RUN);
    // inject one update token per grid row after the first
    assign act_src        = (state_reg == ST_RUN) && (STEP_W'(rows_m1_reg) > step_reg);
    assign cols_used      = cols_reg;
    assign stat.fin       = (state_reg == ST_FIN);
    assign stat.zero      = zero_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fin |=> !busy)
        else $error("busy held after result");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.run && (step_reg == end_reg)) |=> stat.fin)
        else $error("sweep end did not reach result state");

    a_token_window: assert property (@(posedge clk) disable iff (!rst_n)
        act_src |-> (cell_ctrl.run && (step_reg < end_reg)))
        else $error("row token injected outside sweep");

endmodule

FILE: hdl/lattice_path_counter_top.sv
`timescale 1ns / 1ps

// Lattice path counter: a beat on start (taken while busy is low) carries a
// grid size rows x cols; one result beat later shows path_count, the number
// of monotone right/down paths corner to corner, saturated at the count
// range, with overflow set if any partial sum saturated. Dimensions above
// MAX_DIM are clamped to MAX_DIM; a zero dimension gives count 0, overflow 0.
// Otherwise the result strobe (done) follows a sweep through the cell row.
// In both cases busy drops as done rises, so a new request can be taken in
// the cycle that shows the result. The sweep runs through the row of
// MAX_DIM cells: each holds one entry of the row store, row updates sweep
// through it as a diagonal wavefront, and the final count then drains to
// the tail cell, which is the only one read. done is high for exactly one
// cycle per request and the receiver cannot hold it off: capture the
// result in that cycle.
module lattice_path_counter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  lpc_pkg::lpc_dim_in_t          rows,
    input  lpc_pkg::lpc_dim_in_t          cols,
    output logic                          busy,
    output logic                          done,
    output logic [lpc_pkg::COUNT_OUT_W-1:0] path_count,
    output logic                          overflow
);
    import lpc_pkg::*;

    lpc_cell_ctrl_t cell_ctrl;
    lpc_seq_stat_t  stat;
    logic           act_src;
    lpc_dim_t       cols_used;

    // chain links: index j is the input side of cell j
    logic       act_link [MAX_DIM+1];
    lpc_count_t val_link [MAX_DIM+1];
    logic [MAX_DIM-1:0] ovf_vec;

    logic [COUNT_OUT_W-1:0] path_count_reg;
    logic [COUNT_OUT_W-1:0] path_count_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic                   done_reg;

    lpc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .rows      (rows),
        .cols      (cols),
        .busy      (busy),
        .cell_ctrl (cell_ctrl),
        .act_src   (act_src),
        .cols_used (cols_used),
        .stat      (stat)
    );

    // Head of the chain: cell 0 adds zero, so its value stays at one while
    // it passes the row tokens on.
    assign act_link[0] = act_src;
    assign val_link[0] = '0;

    genvar j;
    generate
        for (j = 0; j < MAX_DIM; j++)
        begin : g_cell
            logic col_en;

            // cells at or past cols only forward the count toward the tail
            assign col_en = (DIM_W'(j) < cols_used);

            lpc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .col_en   (col_en),
                .left_act (act_link[j]),
                .left_val (val_link[j]),
                .act      (act_link[j+1]),
                .val      (val_link[j+1]),
                .ovf      (ovf_vec[j])
            );
        end
    endgenerate

    // Capture the result beat; zero-size requests report nothing found.
    always_comb
    begin
        path_count_next = path_count_reg;
        overflow_next   = overflow_reg;
        if (stat.fin)
        begin
            if (stat.zero)
            begin
                path_count_next = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                path_count_next = COUNT_OUT_W'(val_link[MAX_DIM]);
                overflow_next   = |ovf_vec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stat.fin;
    end

    always_ff @(posedge clk)
    begin
        path_count_reg <= path_count_next;
        overflow_reg   <= overflow_next;
    end

    assign done       = done_reg;
    assign path_count = path_count_reg;
    assign overflow   = overflow_reg;

endmodule
